### rtl/necir_pkg.sv
// necir_pkg: shared types, codes and constants of the NEC infrared edge decoder
// no dependencies; used by every module of the decoder by scoped names
`timescale 1ns / 1ps

package necir_pkg;

  // byte ring, split into an even and an odd bank (depth is a power of two)
  localparam int unsigned RING_DEPTH = 128;
  localparam int unsigned RING_AW    = $clog2(RING_DEPTH);
  localparam int unsigned BANK_DEPTH = RING_DEPTH / 2;
  localparam int unsigned BANK_AW    = RING_AW - 1;

  // request queue between front and back, and result queue at the output
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CW    = QUEUE_AW + 1;
  localparam logic [QUEUE_CW-1:0] QUEUE_FULL_CNT = QUEUE_CW'(QUEUE_DEPTH);

  // edge positions within a frame
  localparam int unsigned EDGE_CW = 7;
  localparam logic [EDGE_CW-1:0] EDGE_MARK      = 7'd2;
  localparam logic [EDGE_CW-1:0] EDGE_SPACE     = 7'd3;
  localparam logic [EDGE_CW-1:0] EDGE_LEADER    = 7'd4;
  localparam logic [EDGE_CW-1:0] EDGE_FIRST_BIT = 7'd5;
  localparam logic [EDGE_CW-1:0] FRAME_EDGES    = 7'd68;

  // request kinds, coded as the func field
  typedef enum logic [1:0] {
    OP_EDGE    = 2'd0,
    OP_TIMEOUT = 2'd1,
    OP_READ    = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  // status codes of a result
  localparam logic [2:0] ST_BUSY       = 3'd0;
  localparam logic [2:0] ST_FRAME      = 3'd1;
  localparam logic [2:0] ST_REPEAT     = 3'd2;
  localparam logic [2:0] ST_LEADER_ERR = 3'd3;
  localparam logic [2:0] ST_CHECK_ERR  = 3'd4;
  localparam logic [2:0] ST_TIMEOUT    = 3'd5;
  localparam logic [2:0] ST_READ_DATA  = 3'd6;
  localparam logic [2:0] ST_READ_EMPTY = 3'd7;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_LEADER_MARK_MIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEADER_MARK_MAX  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_SPACE_MIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_SPACE_MAX = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_START_SPACE_MIN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_START_SPACE_MAX  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_THRESHOLD    = 3'd6;

  // configuration reset values, nanoseconds
  localparam logic [31:0] RST_LEADER_MARK_MIN  = 32'd8000000;
  localparam logic [31:0] RST_LEADER_MARK_MAX  = 32'd10000000;
  localparam logic [31:0] RST_REPEAT_SPACE_MIN = 32'd2000000;
  localparam logic [31:0] RST_REPEAT_SPACE_MAX = 32'd2500000;
  localparam logic [31:0] RST_START_SPACE_MIN  = 32'd3500000;
  localparam logic [31:0] RST_START_SPACE_MAX  = 32'd5500000;
  localparam logic [31:0] RST_ONE_THRESHOLD    = 32'd1000000;

  localparam logic [7:0] ERR_BYTE = 8'hFF;

  // classified request from the front to the back
  typedef struct packed {
    op_e         op;
    logic [31:0] gap;
  } item_t;

  // ring access issued by the back for one request
  typedef struct packed {
    logic               wr_first;
    logic               wr_second;
    logic [RING_AW-1:0] wr_addr;
    logic [7:0]         wr_first_data;
    logic [7:0]         wr_second_data;
    logic               rd_en;
    logic [RING_AW-1:0] rd_addr;
  } ring_req_t;

  // one result as held in the output queue
  typedef struct packed {
    logic [2:0] status;
    logic [7:0] first;
    logic [7:0] second;
    logic       armed;
  } result_t;

endpackage

### rtl/necir_front.sv
// necir_front: input side; gap measurement, request classification, request queue
// depends on necir_pkg
`timescale 1ns / 1ps

module necir_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  logic [1:0]           func_i,
  input  logic [63:0]          edge_time_i,
  output logic                 item_valid_o,
  output necir_pkg::item_t     item_o,
  input  logic                 item_take_i
);

  logic [63:0]                    prev_time_q;
  logic [63:0]                    delta;
  necir_pkg::item_t               new_item;
  necir_pkg::item_t               queue_q [necir_pkg::QUEUE_DEPTH];
  logic [necir_pkg::QUEUE_AW-1:0] wr_ptr_q;
  logic [necir_pkg::QUEUE_AW-1:0] rd_ptr_q;
  logic [necir_pkg::QUEUE_CW-1:0] count_q;
  logic                           accept;

  assign full   = (count_q == necir_pkg::QUEUE_FULL_CNT);
  assign accept = push && !full;

  // gap to previous edge, saturated to 32 bits
  assign delta = edge_time_i - prev_time_q;
  always_comb begin
    new_item.op  = necir_pkg::op_e'(func_i);
    new_item.gap = (|delta[63:32]) ? 32'hFFFF_FFFF : delta[31:0];
  end

  // previous edge time
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_time_q <= '0;
    end else if (accept && (new_item.op == necir_pkg::OP_EDGE)) begin
      prev_time_q <= edge_time_i;
    end
  end

  // request queue storage
  always_ff @(posedge clk_i) begin
    if (accept) begin
      queue_q[wr_ptr_q] <= new_item;
    end
  end

  // request queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (accept) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (item_take_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (accept && !item_take_i) begin
        count_q <= count_q + 1'b1;
      end else if (!accept && item_take_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  assign item_valid_o = (count_q != '0);
  assign item_o       = queue_q[rd_ptr_q];

endmodule

### rtl/necir_ring.sv
// necir_ring: byte ring storage in two banks, two bytes written and read per cycle
// depends on necir_pkg; pointers are kept by the caller
`timescale 1ns / 1ps

module necir_ring (
  input  logic                  clk_i,
  input  necir_pkg::ring_req_t  req_i,
  output logic [7:0]            first_o,
  output logic [7:0]            second_o
);

  logic [7:0] even_mem [necir_pkg::BANK_DEPTH];
  logic [7:0] odd_mem  [necir_pkg::BANK_DEPTH];

  logic [necir_pkg::RING_AW-1:0] wr_next;
  logic [necir_pkg::RING_AW-1:0] rd_next;
  logic                          even_we;
  logic                          odd_we;
  logic [necir_pkg::BANK_AW-1:0] even_wa;
  logic [necir_pkg::BANK_AW-1:0] odd_wa;
  logic [7:0]                    even_wd;
  logic [7:0]                    odd_wd;
  logic [necir_pkg::BANK_AW-1:0] even_ra;
  logic [necir_pkg::BANK_AW-1:0] odd_ra;
  logic [7:0]                    even_rd_q;
  logic [7:0]                    odd_rd_q;
  logic                          swap_q;

  assign wr_next = req_i.wr_addr + 1'b1;
  assign rd_next = req_i.rd_addr + 1'b1;

  // route the two bytes to the bank that owns each address
  always_comb begin
    if (req_i.wr_addr[0]) begin
      odd_we  = req_i.wr_first;
      odd_wa  = req_i.wr_addr[necir_pkg::RING_AW-1:1];
      odd_wd  = req_i.wr_first_data;
      even_we = req_i.wr_second;
      even_wa = wr_next[necir_pkg::RING_AW-1:1];
      even_wd = req_i.wr_second_data;
    end else begin
      even_we = req_i.wr_first;
      even_wa = req_i.wr_addr[necir_pkg::RING_AW-1:1];
      even_wd = req_i.wr_first_data;
      odd_we  = req_i.wr_second;
      odd_wa  = wr_next[necir_pkg::RING_AW-1:1];
      odd_wd  = req_i.wr_second_data;
    end
    if (req_i.rd_addr[0]) begin
      odd_ra  = req_i.rd_addr[necir_pkg::RING_AW-1:1];
      even_ra = rd_next[necir_pkg::RING_AW-1:1];
    end else begin
      even_ra = req_i.rd_addr[necir_pkg::RING_AW-1:1];
      odd_ra  = rd_next[necir_pkg::RING_AW-1:1];
    end
  end

  // bank writes and registered reads
  always_ff @(posedge clk_i) begin
    if (even_we) begin
      even_mem[even_wa] <= even_wd;
    end
    if (odd_we) begin
      odd_mem[odd_wa] <= odd_wd;
    end
    if (req_i.rd_en) begin
      even_rd_q <= even_mem[even_ra];
      odd_rd_q  <= odd_mem[odd_ra];
      swap_q    <= req_i.rd_addr[0];
    end
  end

  // put the bytes back in ring order
  assign first_o  = swap_q ? odd_rd_q : even_rd_q;
  assign second_o = swap_q ? even_rd_q : odd_rd_q;

endmodule

### rtl/necir_back.sv
// necir_back: frame decoding, ring pointers, configuration registers, result queue
// depends on necir_pkg; ring storage sits in necir_ring
`timescale 1ns / 1ps

module necir_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic [necir_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [31:0]                       cfg_data_i,
  input  logic                              item_valid_i,
  input  necir_pkg::item_t                  item_i,
  output logic                              item_take_o,
  output necir_pkg::ring_req_t              ring_req_o,
  input  logic [7:0]                        ring_first_i,
  input  logic [7:0]                        ring_second_i,
  output logic                              empty,
  input  logic                              pop,
  output logic [2:0]                        status_o,
  output logic [7:0]                        read_first_o,
  output logic [7:0]                        read_second_o,
  output logic                              timer_armed_o
);

  // configuration registers
  logic [31:0] mark_min_q, mark_max_q;
  logic [31:0] rep_min_q, rep_max_q;
  logic [31:0] start_min_q, start_max_q;
  logic [31:0] one_thr_q;

  // decoder state
  logic [necir_pkg::EDGE_CW-1:0] edge_cnt_q, edge_cnt_d, cnt_n;
  logic                          mark_good_q, mark_good_d;
  logic [31:0]                   space_gap_q, space_gap_d;
  logic [31:0]                   bits_q, bits_d;
  logic                          armed_q, armed_d;
  logic [necir_pkg::RING_AW-1:0] rp_q, rp_d, wp_q, wp_d;
  logic [necir_pkg::RING_AW-1:0] ring_free, ring_avail;

  // decode stage outputs
  logic       fire;
  logic [2:0] s1_status;
  logic [7:0] s1_first, s1_second;
  logic       s1_from_ring, s1_two;
  logic       push_en;
  logic [7:0] push_first, push_second;
  logic       is_repeat, is_start;

  // ring read stage
  logic       s2_valid_q;
  logic [2:0] s2_status_q;
  logic [7:0] s2_first_q, s2_second_q;
  logic       s2_armed_q, s2_from_ring_q, s2_two_q;
  necir_pkg::result_t s2_result;

  // result queue
  necir_pkg::result_t             out_q [necir_pkg::QUEUE_DEPTH];
  logic [necir_pkg::QUEUE_AW-1:0] out_wr_q, out_rd_q;
  logic [necir_pkg::QUEUE_CW-1:0] out_cnt_q, out_used;
  logic                           out_pop;

  function automatic logic in_range(logic [31:0] v, logic [31:0] lo, logic [31:0] hi);
    return (v >= lo) && (v <= hi);
  endfunction

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mark_min_q  <= necir_pkg::RST_LEADER_MARK_MIN;
      mark_max_q  <= necir_pkg::RST_LEADER_MARK_MAX;
      rep_min_q   <= necir_pkg::RST_REPEAT_SPACE_MIN;
      rep_max_q   <= necir_pkg::RST_REPEAT_SPACE_MAX;
      start_min_q <= necir_pkg::RST_START_SPACE_MIN;
      start_max_q <= necir_pkg::RST_START_SPACE_MAX;
      one_thr_q   <= necir_pkg::RST_ONE_THRESHOLD;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        necir_pkg::CFG_LEADER_MARK_MIN:  mark_min_q  <= cfg_data_i;
        necir_pkg::CFG_LEADER_MARK_MAX:  mark_max_q  <= cfg_data_i;
        necir_pkg::CFG_REPEAT_SPACE_MIN: rep_min_q   <= cfg_data_i;
        necir_pkg::CFG_REPEAT_SPACE_MAX: rep_max_q   <= cfg_data_i;
        necir_pkg::CFG_START_SPACE_MIN:  start_min_q <= cfg_data_i;
        necir_pkg::CFG_START_SPACE_MAX:  start_max_q <= cfg_data_i;
        necir_pkg::CFG_ONE_THRESHOLD:    one_thr_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // take a request only when its result has a guaranteed slot
  assign out_used    = out_cnt_q + necir_pkg::QUEUE_CW'(s2_valid_q);
  assign fire        = item_valid_i && (out_used < necir_pkg::QUEUE_FULL_CNT);
  assign item_take_o = fire;

  assign cnt_n      = edge_cnt_q + 1'b1;
  assign ring_free  = rp_q - wp_q - 1'b1;
  assign ring_avail = wp_q - rp_q;
  assign is_repeat  = mark_good_q && in_range(space_gap_q, rep_min_q, rep_max_q);
  assign is_start   = mark_good_q && in_range(space_gap_q, start_min_q, start_max_q);

  // decode one request
  always_comb begin
    edge_cnt_d   = edge_cnt_q;
    mark_good_d  = mark_good_q;
    space_gap_d  = space_gap_q;
    bits_d       = bits_q;
    armed_d      = armed_q;
    rp_d         = rp_q;
    s1_status    = necir_pkg::ST_BUSY;
    s1_first     = 8'h00;
    s1_second    = 8'h00;
    s1_from_ring = 1'b0;
    s1_two       = 1'b0;
    push_en      = 1'b0;
    push_first   = necir_pkg::ERR_BYTE;
    push_second  = necir_pkg::ERR_BYTE;
    if (fire) begin
      case (item_i.op)
        necir_pkg::OP_EDGE: begin
          edge_cnt_d = cnt_n;
          armed_d    = 1'b1;
          if (cnt_n == necir_pkg::EDGE_MARK) begin
            mark_good_d = in_range(item_i.gap, mark_min_q, mark_max_q);
          end else if (cnt_n == necir_pkg::EDGE_SPACE) begin
            space_gap_d = item_i.gap;
          end else if (cnt_n == necir_pkg::EDGE_LEADER) begin
            if (is_repeat) begin
              edge_cnt_d = '0;
              armed_d    = 1'b0;
              s1_status  = necir_pkg::ST_REPEAT;
            end else if (!is_start) begin
              edge_cnt_d = '0;
              armed_d    = 1'b0;
              s1_status  = necir_pkg::ST_LEADER_ERR;
            end
          end else if ((cnt_n >= necir_pkg::EDGE_FIRST_BIT) &&
                       (cnt_n < necir_pkg::FRAME_EDGES) && cnt_n[0]) begin
            bits_d = {bits_q[30:0], (item_i.gap > one_thr_q)};
          end else if (cnt_n >= necir_pkg::FRAME_EDGES) begin
            edge_cnt_d = '0;
            armed_d    = 1'b0;
            push_en    = 1'b1;
            if ((bits_q[23:16] == ~bits_q[31:24]) && (bits_q[7:0] == ~bits_q[15:8])) begin
              push_first  = bits_q[31:24];
              push_second = bits_q[15:8];
              s1_status   = necir_pkg::ST_FRAME;
            end else begin
              s1_status = necir_pkg::ST_CHECK_ERR;
            end
          end
        end
        necir_pkg::OP_TIMEOUT: begin
          if (armed_q) begin
            armed_d    = 1'b0;
            edge_cnt_d = '0;
            push_en    = 1'b1;
            s1_status  = necir_pkg::ST_TIMEOUT;
          end
        end
        necir_pkg::OP_READ: begin
          if (ring_avail != '0) begin
            s1_from_ring = 1'b1;
            s1_two       = (ring_avail != necir_pkg::RING_AW'(1));
            rp_d         = rp_q + necir_pkg::RING_AW'({s1_two, ~s1_two});
            s1_status    = necir_pkg::ST_READ_DATA;
          end else begin
            s1_first  = necir_pkg::ERR_BYTE;
            s1_second = necir_pkg::ERR_BYTE;
            s1_status = necir_pkg::ST_READ_EMPTY;
          end
        end
        default: ;
      endcase
    end
  end

  // ring access; a push to a full ring drops the byte
  always_comb begin
    ring_req_o.wr_first       = push_en && (ring_free != '0);
    ring_req_o.wr_second      = push_en && (ring_free > necir_pkg::RING_AW'(1));
    ring_req_o.wr_addr        = wp_q;
    ring_req_o.wr_first_data  = push_first;
    ring_req_o.wr_second_data = push_second;
    ring_req_o.rd_en          = s1_from_ring;
    ring_req_o.rd_addr        = rp_q;
  end
  assign wp_d = wp_q + necir_pkg::RING_AW'(ring_req_o.wr_first)
                     + necir_pkg::RING_AW'(ring_req_o.wr_second);

  // decoder state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_cnt_q  <= '0;
      mark_good_q <= 1'b0;
      space_gap_q <= '0;
      bits_q      <= '0;
      armed_q     <= 1'b0;
      rp_q        <= '0;
      wp_q        <= '0;
    end else begin
      edge_cnt_q  <= edge_cnt_d;
      mark_good_q <= mark_good_d;
      space_gap_q <= space_gap_d;
      bits_q      <= bits_d;
      armed_q     <= armed_d;
      rp_q        <= rp_d;
      wp_q        <= wp_d;
    end
  end

  // ring read stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= fire;
    end
  end

  // ring read stage payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      s2_status_q    <= s1_status;
      s2_first_q     <= s1_first;
      s2_second_q    <= s1_second;
      s2_armed_q     <= armed_d;
      s2_from_ring_q <= s1_from_ring;
      s2_two_q       <= s1_two;
    end
  end

  // merge ring bytes into the result
  always_comb begin
    s2_result.status = s2_status_q;
    s2_result.armed  = s2_armed_q;
    if (s2_from_ring_q) begin
      s2_result.first  = ring_first_i;
      s2_result.second = s2_two_q ? ring_second_i : 8'h00;
    end else begin
      s2_result.first  = s2_first_q;
      s2_result.second = s2_second_q;
    end
  end

  // result queue storage
  always_ff @(posedge clk_i) begin
    if (s2_valid_q) begin
      out_q[out_wr_q] <= s2_result;
    end
  end

  assign empty   = (out_cnt_q == '0);
  assign out_pop = pop && !empty;

  // result queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_wr_q  <= '0;
      out_rd_q  <= '0;
      out_cnt_q <= '0;
    end else begin
      if (s2_valid_q) begin
        out_wr_q <= out_wr_q + 1'b1;
      end
      if (out_pop) begin
        out_rd_q <= out_rd_q + 1'b1;
      end
      if (s2_valid_q && !out_pop) begin
        out_cnt_q <= out_cnt_q + 1'b1;
      end else if (!s2_valid_q && out_pop) begin
        out_cnt_q <= out_cnt_q - 1'b1;
      end
    end
  end

  assign status_o      = out_q[out_rd_q].status;
  assign read_first_o  = out_q[out_rd_q].first;
  assign read_second_o = out_q[out_rd_q].second;
  assign timer_armed_o = out_q[out_rd_q].armed;

endmodule

### rtl/nec_ir_edge_decoder_core.sv
// path: a pushed request passes the request queue, the ring read stage and the result queue before empty goes low
// throughput: one request per cycle; the 4-entry request and result queues absorb stalls
// each request is decoded combinationally; ring reads land in the next cycle from the banked ring
// reset: asynchronous, active low; clears pointers, counters, queues and decoder state,
// and loads the default timing registers; ring contents are not cleared and need no sweep
// top level of the NEC infrared edge decoder; depends on necir_pkg, front, ring and back
`timescale 1ns / 1ps

module nec_ir_edge_decoder_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [necir_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                     cfg_data_i,
  input  logic                            push,
  output logic                            full,
  input  logic [1:0]                      func_i,
  input  logic [63:0]                     edge_time_i,
  output logic                            empty,
  input  logic                            pop,
  output logic [2:0]                      status_o,
  output logic [7:0]                      read_first_o,
  output logic [7:0]                      read_second_o,
  output logic                            timer_armed_o
);

  logic                 item_valid;
  logic                 item_take;
  necir_pkg::item_t     item;
  necir_pkg::ring_req_t ring_req;
  logic [7:0]           ring_first;
  logic [7:0]           ring_second;

  // configuration writes are always taken
  assign cfg_ready_o = 1'b1;

  // request intake and gap measurement
  necir_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .func_i       (func_i),
    .edge_time_i  (edge_time_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_take_i  (item_take)
  );

  // byte ring storage
  necir_ring u_ring (
    .clk_i    (clk_i),
    .req_i    (ring_req),
    .first_o  (ring_first),
    .second_o (ring_second)
  );

  // frame decoding and results
  necir_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .item_valid_i  (item_valid),
    .item_i        (item),
    .item_take_o   (item_take),
    .ring_req_o    (ring_req),
    .ring_first_i  (ring_first),
    .ring_second_i (ring_second),
    .empty         (empty),
    .pop           (pop),
    .status_o      (status_o),
    .read_first_o  (read_first_o),
    .read_second_o (read_second_o),
    .timer_armed_o (timer_armed_o)
  );

endmodule

### dv/nec_ir_edge_decoder_core_test.sv
// nec_ir_edge_decoder_core_test: self-checking bench for the NEC infrared edge decoder
// drives edge, timeout and read requests, predicts every result in-bench and checks it
// depends on necir_pkg and nec_ir_edge_decoder_core only
`timescale 1ns / 1ps

module nec_ir_edge_decoder_core_test;

  localparam int unsigned RUN_LIMIT_NS = 20_000_000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned FILL_HOLD_CYCLES = 400;

  // timing registers in index order
  localparam logic [31:0] DEFAULT_TIMING [7] = '{
    necir_pkg::RST_LEADER_MARK_MIN, necir_pkg::RST_LEADER_MARK_MAX,
    necir_pkg::RST_REPEAT_SPACE_MIN, necir_pkg::RST_REPEAT_SPACE_MAX,
    necir_pkg::RST_START_SPACE_MIN, necir_pkg::RST_START_SPACE_MAX,
    necir_pkg::RST_ONE_THRESHOLD
  };

  // results that can be read off directly
  localparam necir_pkg::result_t R_NONE     = '0;
  localparam necir_pkg::result_t R_IDLE     = '{necir_pkg::ST_BUSY, 8'h00, 8'h00, 1'b0};
  localparam necir_pkg::result_t R_ARMED    = '{necir_pkg::ST_BUSY, 8'h00, 8'h00, 1'b1};
  localparam necir_pkg::result_t R_EMPTY    = '{necir_pkg::ST_READ_EMPTY, necir_pkg::ERR_BYTE,
                                                necir_pkg::ERR_BYTE, 1'b0};
  localparam necir_pkg::result_t R_TIMEOUT  = '{necir_pkg::ST_TIMEOUT, 8'h00, 8'h00, 1'b0};
  localparam necir_pkg::result_t R_ERR_PAIR = '{necir_pkg::ST_READ_DATA, necir_pkg::ERR_BYTE,
                                                necir_pkg::ERR_BYTE, 1'b0};
  localparam necir_pkg::result_t R_REPEAT   = '{necir_pkg::ST_REPEAT, 8'h00, 8'h00, 1'b0};
  localparam necir_pkg::result_t R_LEADER_ERR = '{necir_pkg::ST_LEADER_ERR, 8'h00, 8'h00, 1'b0};

  typedef struct {
    necir_pkg::op_e     op;
    logic [63:0]        stamp;
    bit                 typed;
    necir_pkg::result_t want;
  } stim_row_t;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_valid_i;
  logic                            cfg_ready_o;
  logic [necir_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [31:0]                     cfg_data_i;
  logic                            push;
  logic                            full;
  logic [1:0]                      func_i;
  logic [63:0]                     edge_time_i;
  logic                            empty;
  logic                            pop;
  logic [2:0]                      status_o;
  logic [7:0]                      read_first_o;
  logic [7:0]                      read_second_o;
  logic                            timer_armed_o;

  nec_ir_edge_decoder_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .push          (push),
    .full          (full),
    .func_i        (func_i),
    .edge_time_i   (edge_time_i),
    .empty         (empty),
    .pop           (pop),
    .status_o      (status_o),
    .read_first_o  (read_first_o),
    .read_second_o (read_second_o),
    .timer_armed_o (timer_armed_o)
  );

  // directed requests: reset state, special cases, range boundaries
  stim_row_t directed_rows [26] = '{
    '{necir_pkg::OP_READ,    64'd0,                   1'b1, R_EMPTY},
    '{necir_pkg::OP_TIMEOUT, 64'd0,                   1'b1, R_IDLE},
    '{necir_pkg::OP_NONE,    64'hFFFF_FFFF_FFFF_FFFF, 1'b1, R_IDLE},
    '{necir_pkg::OP_EDGE,    64'd1_000,               1'b1, R_ARMED},
    '{necir_pkg::OP_TIMEOUT, 64'd0,                   1'b1, R_TIMEOUT},
    '{necir_pkg::OP_READ,    64'd0,                   1'b1, R_ERR_PAIR},
    '{necir_pkg::OP_EDGE,    64'd2_000_000,           1'b1, R_ARMED},
    '{necir_pkg::OP_EDGE,    64'd11_000_000,          1'b1, R_ARMED},
    '{necir_pkg::OP_EDGE,    64'd13_250_000,          1'b1, R_ARMED},
    '{necir_pkg::OP_EDGE,    64'd13_810_000,          1'b1, R_REPEAT},
    '{necir_pkg::OP_EDGE,    64'hFFFF_FFFF_FFFF_FFFF, 1'b1, R_ARMED},
    '{necir_pkg::OP_EDGE,    64'd5,                   1'b1, R_ARMED},
    '{necir_pkg::OP_EDGE,    64'd3,                   1'b1, R_ARMED},
    '{necir_pkg::OP_EDGE,    64'd4,                   1'b1, R_LEADER_ERR},
    '{necir_pkg::OP_EDGE,    64'd100,                 1'b0, R_NONE},
    '{necir_pkg::OP_EDGE,    64'd8_000_100,           1'b0, R_NONE},
    '{necir_pkg::OP_EDGE,    64'd13_500_100,          1'b0, R_NONE},
    '{necir_pkg::OP_EDGE,    64'd14_060_100,          1'b0, R_NONE},
    '{necir_pkg::OP_EDGE,    64'd15_060_101,          1'b0, R_NONE},
    '{necir_pkg::OP_EDGE,    64'd16_060_101,          1'b0, R_NONE},
    '{necir_pkg::OP_TIMEOUT, 64'hA5A5_5A5A_0F0F_F0F0, 1'b1, R_TIMEOUT},
    '{necir_pkg::OP_READ,    64'h5A5A_A5A5_F0F0_0F0F, 1'b1, R_ERR_PAIR},
    '{necir_pkg::OP_EDGE,    64'd20_000_000,          1'b0, R_NONE},
    '{necir_pkg::OP_EDGE,    64'd30_000_000,          1'b0, R_NONE},
    '{necir_pkg::OP_EDGE,    64'd32_000_000,          1'b0, R_NONE},
    '{necir_pkg::OP_EDGE,    64'd32_560_000,          1'b1, R_REPEAT}
  };

  // decoder state as predicted
  logic [31:0] timing_now [8];
  logic [63:0] last_stamp = '0;
  int unsigned edge_no = 0;
  logic        mark_ok = 1'b0;
  logic [31:0] space_gap = '0;
  logic [31:0] data_bits = '0;
  logic [7:0]  ring_copy [necir_pkg::RING_DEPTH];
  int unsigned rd_ptr = 0;
  int unsigned wr_ptr = 0;
  logic        timer_on = 1'b0;

  // bench bookkeeping
  necir_pkg::result_t awaited_results [$];
  logic [31:0] next_timing [8];
  logic [63:0] edge_clock_ns = '0;
  int          sent_count = 0;
  int          mismatch_count = 0;
  int          idle_max = 19;
  int          hold_cycles = 0;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #(RUN_LIMIT_NS);
    $display("CHECK FAILED");
    $finish;
  end

  function automatic bit in_window(logic [31:0] v, logic [31:0] lo, logic [31:0] hi);
    return v >= lo && v <= hi;
  endfunction

  function automatic void ring_put(logic [7:0] b);
    if ((wr_ptr + 1) % necir_pkg::RING_DEPTH != rd_ptr) begin
      ring_copy[wr_ptr] = b;
      wr_ptr = (wr_ptr + 1) % necir_pkg::RING_DEPTH;
    end
  endfunction

  function automatic logic [7:0] ring_take();
    logic [7:0] b;
    b = 8'h00;
    if (rd_ptr != wr_ptr) begin
      b = ring_copy[rd_ptr];
      rd_ptr = (rd_ptr + 1) % necir_pkg::RING_DEPTH;
    end
    return b;
  endfunction

  // one edge: gap measure, leader check, bit shift, frame end
  function automatic logic [2:0] decode_edge(logic [63:0] t);
    logic [63:0] diff;
    logic [31:0] gap;
    logic [7:0]  b0, b1, b2, b3;
    diff = t - last_stamp;
    gap = (diff > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : diff[31:0];
    last_stamp = t;
    edge_no++;
    if (edge_no == necir_pkg::EDGE_MARK) begin
      mark_ok = in_window(gap, timing_now[necir_pkg::CFG_LEADER_MARK_MIN],
                          timing_now[necir_pkg::CFG_LEADER_MARK_MAX]);
    end else if (edge_no == necir_pkg::EDGE_SPACE) begin
      space_gap = gap;
    end else if (edge_no == necir_pkg::EDGE_LEADER) begin
      // repeat code is tested first
      if (mark_ok && in_window(space_gap, timing_now[necir_pkg::CFG_REPEAT_SPACE_MIN],
                               timing_now[necir_pkg::CFG_REPEAT_SPACE_MAX])) begin
        edge_no = 0;
        timer_on = 1'b0;
        return necir_pkg::ST_REPEAT;
      end
      if (!(mark_ok && in_window(space_gap, timing_now[necir_pkg::CFG_START_SPACE_MIN],
                                 timing_now[necir_pkg::CFG_START_SPACE_MAX]))) begin
        edge_no = 0;
        timer_on = 1'b0;
        return necir_pkg::ST_LEADER_ERR;
      end
    end else if (edge_no >= necir_pkg::EDGE_FIRST_BIT && edge_no < necir_pkg::FRAME_EDGES &&
                 edge_no % 2 == 1) begin
      data_bits = {data_bits[30:0], gap > timing_now[necir_pkg::CFG_ONE_THRESHOLD]};
    end else if (edge_no >= necir_pkg::FRAME_EDGES) begin
      {b0, b1, b2, b3} = data_bits;
      edge_no = 0;
      timer_on = 1'b0;
      if (b1 == ~b0 && b3 == ~b2) begin
        ring_put(b0);
        ring_put(b2);
        return necir_pkg::ST_FRAME;
      end
      ring_put(necir_pkg::ERR_BYTE);
      ring_put(necir_pkg::ERR_BYTE);
      return necir_pkg::ST_CHECK_ERR;
    end
    timer_on = 1'b1;
    return necir_pkg::ST_BUSY;
  endfunction

  function automatic necir_pkg::result_t decode_request(necir_pkg::op_e op, logic [63:0] t);
    necir_pkg::result_t r;
    r = '0;
    case (op)
      necir_pkg::OP_EDGE: r.status = decode_edge(t);
      necir_pkg::OP_TIMEOUT: begin
        if (timer_on) begin
          timer_on = 1'b0;
          edge_no = 0;
          ring_put(necir_pkg::ERR_BYTE);
          ring_put(necir_pkg::ERR_BYTE);
          r.status = necir_pkg::ST_TIMEOUT;
        end
      end
      necir_pkg::OP_READ: begin
        if (rd_ptr != wr_ptr) begin
          r.first = ring_take();
          r.second = ring_take();
          r.status = necir_pkg::ST_READ_DATA;
        end else begin
          r.first = necir_pkg::ERR_BYTE;
          r.second = necir_pkg::ERR_BYTE;
          r.status = necir_pkg::ST_READ_EMPTY;
        end
      end
      default: ;
    endcase
    r.armed = timer_on;
    return r;
  endfunction

  // gap inside a window, at its bounds, or just outside
  function automatic logic [63:0] pick_gap(logic [31:0] lo, logic [31:0] hi);
    logic [63:0] lo_w, hi_w;
    lo_w = {32'd0, lo};
    hi_w = {32'd0, hi};
    case ($urandom_range(0, 15))
      0: return lo_w;
      1: return hi_w;
      2: return lo_w - 64'd1;
      3: return hi_w + 64'd1;
      default: return (lo <= hi) ? 64'($urandom_range(hi, lo)) : {32'd0, $urandom};
    endcase
  endfunction

  // one request, after a random idle gap; predicted on acceptance
  task automatic send_request(necir_pkg::op_e op, logic [63:0] t, bit typed = 1'b0,
                              necir_pkg::result_t want = '0);
    int gap;
    necir_pkg::result_t predicted;
    gap = $urandom_range(0, idle_max);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    func_i <= op;
    edge_time_i <= t;
    do @(posedge clk_i); while (full);
    predicted = decode_request(op, t);
    awaited_results.push_back(typed ? want : predicted);
    sent_count++;
  endtask

  task automatic send_edge(logic [63:0] gap);
    edge_clock_ns = edge_clock_ns + gap;
    send_request(necir_pkg::OP_EDGE, edge_clock_ns);
  endtask

  // leader, then data bits; a short edge count leaves the frame open
  task automatic send_frame(bit repeat_code, bit valid, int edges);
    logic [31:0] word;
    logic [31:0] thr;
    logic [7:0]  addr, cmd;
    logic [63:0] g;
    bit          one;
    addr = 8'($urandom);
    cmd = 8'($urandom);
    word = valid ? {addr, ~addr, cmd, ~cmd} : $urandom;
    thr = timing_now[necir_pkg::CFG_ONE_THRESHOLD];
    for (int n = 1; n <= edges; n++) begin
      if (n == 1) begin
        g = 64'($urandom_range(60_000_000, 20_000));
      end else if (n == 2) begin
        g = pick_gap(timing_now[necir_pkg::CFG_LEADER_MARK_MIN],
                     timing_now[necir_pkg::CFG_LEADER_MARK_MAX]);
      end else if (n == 3) begin
        g = repeat_code ?
            pick_gap(timing_now[necir_pkg::CFG_REPEAT_SPACE_MIN],
                     timing_now[necir_pkg::CFG_REPEAT_SPACE_MAX]) :
            pick_gap(timing_now[necir_pkg::CFG_START_SPACE_MIN],
                     timing_now[necir_pkg::CFG_START_SPACE_MAX]);
      end else if (n >= 5 && n % 2 == 1) begin
        one = word[31 - (n - 5) / 2];
        if (one) begin
          g = {32'd0, thr} + 64'd1 + (($urandom_range(0, 3) == 0) ? 0 :
              $urandom_range(600_000, 0));
        end else begin
          g = ($urandom_range(0, 3) == 0) ? {32'd0, thr} : 64'($urandom_range(thr, 0));
        end
      end else begin
        g = 64'($urandom_range(700_000, 400_000));
      end
      send_edge(g);
    end
  endtask

  // mostly well-formed frames, with repeats, cut frames, reads and noise
  task automatic run_random(int budget);
    int             goal;
    int             pick;
    necir_pkg::op_e op;
    logic [63:0]    t;
    goal = sent_count + budget;
    while (sent_count < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        send_frame(1'b0, $urandom_range(0, 3) != 0, int'(necir_pkg::FRAME_EDGES));
      end else if (pick < 60) begin
        send_frame(1'b1, 1'b0, int'(necir_pkg::EDGE_LEADER));
      end else if (pick < 70) begin
        send_frame(1'b0, 1'b1, int'($urandom_range(1, necir_pkg::FRAME_EDGES - 1)));
        if ($urandom_range(0, 1)) send_request(necir_pkg::OP_TIMEOUT, {$urandom, $urandom});
      end else if (pick < 88) begin
        repeat ($urandom_range(1, 3)) send_request(necir_pkg::OP_READ, {$urandom, $urandom});
      end else if (pick < 94) begin
        send_request(necir_pkg::OP_TIMEOUT, {$urandom, $urandom});
      end else begin
        op = necir_pkg::op_e'($urandom_range(0, 3));
        t = {$urandom, $urandom};
        if (op == necir_pkg::OP_EDGE) edge_clock_ns = t;
        send_request(op, t);
      end
    end
  endtask

  // hold the input until every result is back, then let the pipeline settle
  task automatic wait_drained();
    push <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // register set for a phase: scaled, wide open, tight, or random
  task automatic load_phase(int p);
    int unsigned pct;
    pct = (p == 5) ? 100 : $urandom_range(50, 200);
    for (int i = 0; i < 8; i++) next_timing[i] = $urandom;
    case (p)
      1, 5: begin
        for (int i = 0; i < 7; i++) next_timing[i] = 32'((64'(DEFAULT_TIMING[i]) * pct) / 100);
      end
      2: begin
        next_timing[necir_pkg::CFG_LEADER_MARK_MIN]  = 32'h0000_0000;
        next_timing[necir_pkg::CFG_LEADER_MARK_MAX]  = 32'hFFFF_FFFF;
        next_timing[necir_pkg::CFG_REPEAT_SPACE_MIN] = 32'h0000_0000;
        next_timing[necir_pkg::CFG_REPEAT_SPACE_MAX] = 32'hFFFF_FFFF;
        next_timing[necir_pkg::CFG_START_SPACE_MIN]  = 32'h0000_0000;
        next_timing[necir_pkg::CFG_START_SPACE_MAX]  = 32'hFFFF_FFFF;
        next_timing[necir_pkg::CFG_ONE_THRESHOLD]    = 32'h0000_0000;
      end
      3: begin
        next_timing[necir_pkg::CFG_LEADER_MARK_MIN]  = 32'hFFFF_FFFF;
        next_timing[necir_pkg::CFG_LEADER_MARK_MAX]  = 32'hFFFF_FFFF;
        next_timing[necir_pkg::CFG_REPEAT_SPACE_MIN] = 32'h0000_0000;
        next_timing[necir_pkg::CFG_REPEAT_SPACE_MAX] = 32'h0000_0000;
        next_timing[necir_pkg::CFG_START_SPACE_MIN]  = 32'hFFFF_FFFF;
        next_timing[necir_pkg::CFG_START_SPACE_MAX]  = 32'hFFFF_FFFF;
        next_timing[necir_pkg::CFG_ONE_THRESHOLD]    = 32'hFFFF_FFFF;
      end
      default: ;
    endcase
  endtask

  // write all indexes back to back, the unused top index included
  task automatic program_timing();
    for (int i = 0; i < 8; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= necir_pkg::CFG_IDX_W'(i);
      cfg_data_i <= next_timing[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      if (i <= necir_pkg::CFG_ONE_THRESHOLD) timing_now[i] = next_timing[i];
    end
    cfg_valid_i <= 1'b0;
  endtask

  // result side: random stalls, one long hold on request
  initial begin : result_side
    int                 stall;
    necir_pkg::result_t got;
    necir_pkg::result_t want;
    pop <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = (hold_cycles > 0) ? hold_cycles : $urandom_range(0, idle_max);
      hold_cycles = 0;
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      got = '{status_o, read_first_o, read_second_o, timer_armed_o};
      if (awaited_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected result: status %0d first %h second %h armed %b",
                   got.status, got.first, got.second, got.armed);
        end
      end else begin
        want = awaited_results.pop_front();
        if (got.status !== want.status || got.first !== want.first ||
            got.second !== want.second || got.armed !== want.armed) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: expected status %0d first %h second %h armed %b, %s %0d %h %h %b",
                     want.status, want.first, want.second, want.armed, "got",
                     got.status, got.first, got.second, got.armed);
          end
        end
      end
    end
  end

  // request side
  initial begin : request_side
    int phase_items [6];
    phase_items = '{430, 430, 110, 160, 110, 260};
    rst_ni <= 1'b0;
    push <= 1'b0;
    func_i <= necir_pkg::OP_EDGE;
    edge_time_i <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i <= '0;
    for (int i = 0; i < 7; i++) timing_now[i] = DEFAULT_TIMING[i];
    timing_now[7] = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].op, directed_rows[i].stamp, directed_rows[i].typed,
                   directed_rows[i].want);
    end
    edge_clock_ns = directed_rows[25].stamp;

    // fill the ring to overflow while the result side holds off, then drain it
    wait_drained();
    hold_cycles = FILL_HOLD_CYCLES;
    idle_max = 0;
    repeat (necir_pkg::RING_DEPTH / 2) begin
      send_edge(64'd1_000);
      send_request(necir_pkg::OP_TIMEOUT, {$urandom, $urandom});
    end
    repeat (necir_pkg::RING_DEPTH / 2 + 1) send_request(necir_pkg::OP_READ, {$urandom, $urandom});

    // random phases under different register sets
    for (int p = 0; p < 6; p++) begin
      wait_drained();
      if (p > 0) begin
        load_phase(p);
        program_timing();
      end
      idle_max = (p == 1) ? 0 : 19;
      run_random(phase_items[p]);
    end

    wait_drained();
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
